[design/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;
    localparam int FILL_W    = 11;
    localparam int OUT_W     = 48;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

[design/double_ended_queue.sv]
// Double-ended queue of signed words kept in a wrap-around ring memory.
//
// Input channel (s side): tuser carries the operation code (push front,
// push back, pop front, pop back, clear), tdata the word to push.
// Output channel (m side): one result transaction per input transaction,
// tdata packs popped word, status, fill count, empty and full flags.
//
// Pushes, clear, refused operations and unused codes register their
// result at acceptance. A successful pop passes through the registered
// read port of the ring memory: the read is issued at acceptance and the
// word is registered into the output the cycle after.
//
// One operation is in flight at a time. The result sits in an output
// register; a new transaction is taken while that result is being taken
// in the same cycle. When the receiver stalls, the result holds and input
// tready stays low.
//
// Reset (synchronous, active low) empties the queue and drops any pending
// result. Memory contents are not cleared; only written entries are read.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,  // [31:0] value
    input  logic [OP_W-1:0]   i_s_tuser,  // [2:0] operation
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // [31:0] popped, [33:32] status, [44:34] fill_count, [45] is_empty,
    // [46] is_full, [47] zero
    output logic [OUT_W-1:0]  o_m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_front, n_front;
    logic [AW-1:0]            r_back, n_back;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_m_valid, n_m_valid;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    t_status                  r_status, n_status;
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic                     r_empty, n_empty;
    logic                     r_full, n_full;

    logic                     wr_en, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     accept;
    logic                     q_full, q_empty;
    logic [AW-1:0]            front_prev, front_next, back_prev, back_next;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign q_full     = (r_count == FULL_CNT);
    assign q_empty    = (r_count == '0);

    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign back_prev  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;
    assign back_next  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;

    deq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_m_valid = r_m_valid && !i_m_tready;
        n_popped  = r_popped;
        n_status  = r_status;
        wr_en     = 1'b0;
        wr_addr   = r_back;
        rd_en     = 1'b0;
        rd_addr   = r_front;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_popped  = '0;
                    n_status  = STAT_DONE;
                    n_m_valid = 1'b1;
                    case (t_op'(i_s_tuser))
                        OP_PUSH_FRONT: begin
                            if (q_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = front_prev;
                                n_front = front_prev;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (q_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_back;
                                n_back  = back_next;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (q_empty) begin
                                n_status = STAT_EMPTY;
                                n_popped = '1;
                            end else begin
                                // hold the result until the read data returns
                                rd_en     = 1'b1;
                                rd_addr   = r_front;
                                n_front   = front_next;
                                n_count   = r_count - 1'b1;
                                n_m_valid = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        OP_POP_BACK: begin
                            if (q_empty) begin
                                n_status = STAT_EMPTY;
                                n_popped = '1;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = back_prev;
                                n_back    = back_prev;
                                n_count   = r_count - 1'b1;
                                n_m_valid = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        OP_CLEAR: begin
                            n_front = '0;
                            n_back  = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_popped  = rd_data;
                n_m_valid = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_fill  = FILL_W'(n_count);
        n_empty = (n_count == '0);
        n_full  = (n_count == FULL_CNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_front   <= '0;
            r_back    <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_back    <= n_back;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    // Result payload: status and flags load at acceptance, popped word
    // loads at acceptance or from the memory read data in the cycle after.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_fill   <= n_fill;
            r_empty  <= n_empty;
            r_full   <= n_full;
        end
        r_popped <= n_popped;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_full, r_empty, r_fill, r_status, r_popped};

endmodule

[design/deq_ram.sv]
// Ring storage: one write port and one read port with registered read data.
module deq_ram
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [DATA_W-1:0] o_rd_data
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
